// ----- rtl/core/msl_pkg.sv -----
package msl_pkg;

	localparam int NUM_JOINTS = 7;
	localparam int ANGLE_W    = 8;
	localparam int ADDR_W     = $clog2(NUM_JOINTS);
	localparam int OP_W       = 2;
	localparam int PRESET_W   = 2;
	localparam int WORD_W     = 2 * ANGLE_W;
	localparam int IN_DATA_W  = ((PRESET_W + ANGLE_W * NUM_JOINTS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ANGLE_W * NUM_JOINTS + 7) / 8) * 8;

	localparam logic [ANGLE_W-1:0]  ANGLE_MAX  = 8'd180;
	localparam logic [ANGLE_W-1:0]  STEP_RESET = 8'd5;
	localparam logic [PRESET_W-1:0] POSE_HOME  = 2'd0;
	localparam logic [PRESET_W-1:0] POSE_INIT  = 2'd1;
	localparam logic [PRESET_W-1:0] POSE_VERT  = 2'd2;
	localparam logic [ADDR_W-1:0]   LAST_IDX   = ADDR_W'(NUM_JOINTS - 1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_SET    = 2'd1,
		OP_PRESET = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	function automatic logic [ANGLE_W-1:0] pose_angle(
		input logic [PRESET_W-1:0] pose,
		input logic [ADDR_W-1:0]   j
	);
		logic [ANGLE_W-1:0] a;
		a = 8'd90;
		if (pose == POSE_INIT) begin
			unique case (j)
				3'd1:    a = 8'd90;
				3'd2:    a = 8'd30;
				3'd3:    a = 8'd75;
				default: a = 8'd90;
			endcase
		end else if (pose == POSE_VERT) begin
			unique case (j)
				3'd1:    a = 8'd75;
				3'd2:    a = 8'd10;
				3'd3:    a = 8'd180;
				default: a = 8'd90;
			endcase
		end else begin
			unique case (j)
				3'd1:    a = 8'd0;
				3'd2:    a = 8'd180;
				3'd3:    a = 8'd0;
				default: a = 8'd90;
			endcase
		end
		return a;
	endfunction

	function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] v);
		return (v > ANGLE_MAX) ? ANGLE_MAX : v;
	endfunction

endpackage

// ----- rtl/core/msl_ram.sv -----
module msl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/multi_joint_servo_slew_limiter.sv -----
// Each item sweeps the joint RAM once, one joint per cycle through its single read and write
// port; a new item can start its sweep as the last joint of the one before is read.
// Stalls: a tick waits while a finished result is held back by a full output register.
// Reset: max_step returns to 5, every joint's position and target read as the
// home pose until first written; no clearing pass.
module multi_joint_servo_slew_limiter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [msl_pkg::ANGLE_W-1:0]         cfg_data,   // max_step
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [msl_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // preset, angle_0..angle_6
	input  logic [msl_pkg::OP_W-1:0]            s_axis_tuser,  // op
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [msl_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // pos_0..pos_6
);

	localparam int NJ = msl_pkg::NUM_JOINTS;
	localparam int AW = msl_pkg::ADDR_W;
	localparam int VW = msl_pkg::ANGLE_W;
	localparam int PW = msl_pkg::PRESET_W;

	logic [VW-1:0] max_step_q;

	// input buffer
	logic          in_valid_q;
	msl_pkg::op_t  in_op_q;
	logic [PW-1:0] in_preset_q;
	logic [VW-1:0] in_angle_q [NJ];

	// sweep engine
	logic          busy_q;
	logic [AW-1:0] idx_q;
	msl_pkg::op_t  cur_op_q;
	logic [PW-1:0] cur_preset_q;
	logic [VW-1:0] cur_angle_q [NJ];
	logic [NJ-1:0] vld_q;

	// read-data stage
	logic          valid_s1;
	logic [AW-1:0] idx_s1;
	logic          last_s1;
	msl_pkg::op_t  op_s1;
	logic          tgt_we_s1;
	logic [VW-1:0] tgt_s1;
	logic          vld_s1;

	logic          hold_q;
	logic [VW-1:0] acc_pos_q [NJ];
	logic          out_valid_q;
	logic [VW-1:0] out_pos_q [NJ];

	logic          in_acc;
	logic          idx_last;
	logic          free;
	logic          out_free;
	logic          done_tick;
	logic          tick_busy;
	logic          tick_pend;
	logic          start;
	logic          tgt_we;
	logic [VW-1:0] tgt_val;

	logic [2*VW-1:0] rdata;
	logic [2*VW-1:0] wdata;
	logic            we;
	logic [VW-1:0]   old_pos;
	logic [VW-1:0]   old_tgt;
	logic [VW-1:0]   slew_pos;
	logic [VW-1:0]   new_pos;
	logic [VW-1:0]   new_tgt;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !in_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= msl_pkg::STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_step_q <= cfg_data;
		end
	end

	assign idx_last  = idx_q == msl_pkg::LAST_IDX;
	assign free      = !busy_q || idx_last;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign done_tick = valid_s1 && op_s1 == msl_pkg::OP_TICK && last_s1;
	assign tick_busy = busy_q && cur_op_q == msl_pkg::OP_TICK;
	// a tick starts only when the one before it can no longer be held back
	assign tick_pend = (tick_busy && !idx_last) || hold_q ||
	                   ((tick_busy || done_tick) && !out_free);
	assign start     = free && in_valid_q &&
	                   (in_op_q != msl_pkg::OP_TICK || !tick_pend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (in_acc) begin
			in_valid_q <= 1'b1;
		end else if (start) begin
			in_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_op_q     <= msl_pkg::op_t'(s_axis_tuser);
			in_preset_q <= s_axis_tdata[PW-1:0];
			for (int j = 0; j < NJ; j++) begin
				in_angle_q[j] <= s_axis_tdata[PW + VW*j +: VW];
			end
		end
		if (start) begin
			cur_op_q     <= in_op_q;
			cur_preset_q <= in_preset_q;
			cur_angle_q  <= in_angle_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && idx_last) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	always_comb begin
		tgt_we  = 1'b0;
		tgt_val = msl_pkg::clamp_angle(cur_angle_q[idx_q]);
		unique case (cur_op_q)
			msl_pkg::OP_SET: begin
				tgt_we = 1'b1;
			end
			msl_pkg::OP_PRESET: begin
				tgt_we  = cur_preset_q == msl_pkg::POSE_HOME ||
				          cur_preset_q == msl_pkg::POSE_INIT ||
				          cur_preset_q == msl_pkg::POSE_VERT;
				tgt_val = msl_pkg::pose_angle(cur_preset_q, idx_q);
			end
			default: begin
				tgt_we = 1'b0;
			end
		endcase
	end

	// A joint is written in the cycle after its read, before the next sweep reads it again,
	// so accesses to one entry never overlap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= idx_q;
		last_s1   <= idx_last;
		op_s1     <= cur_op_q;
		tgt_we_s1 <= tgt_we;
		tgt_s1    <= tgt_val;
		vld_s1    <= vld_q[idx_q];
	end

	msl_ram #(
		.WIDTH(2 * VW),
		.DEPTH(NJ)
	) u_joint_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wdata),
		.re    (busy_q),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_comb begin
		old_pos = vld_s1 ? rdata[VW-1:0] : msl_pkg::pose_angle(msl_pkg::POSE_HOME, idx_s1);
		old_tgt = vld_s1 ? rdata[2*VW-1:VW] :
		                   msl_pkg::pose_angle(msl_pkg::POSE_HOME, idx_s1);
		if (old_tgt >= old_pos) begin
			slew_pos = (old_tgt - old_pos > max_step_q) ? old_pos + max_step_q : old_tgt;
		end else begin
			slew_pos = (old_pos - old_tgt > max_step_q) ? old_pos - max_step_q : old_tgt;
		end
		new_pos = (op_s1 == msl_pkg::OP_TICK) ? slew_pos : old_pos;
		new_tgt = tgt_we_s1 ? tgt_s1 : old_tgt;
		wdata   = {new_tgt, new_pos};
		we      = valid_s1 && (op_s1 == msl_pkg::OP_TICK || tgt_we_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_q      <= 1'b0;
		end else begin
			if ((done_tick || hold_q) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (done_tick && !out_free) begin
				hold_q <= 1'b1;
			end else if (hold_q && out_free) begin
				hold_q <= 1'b0;
			end
		end
	end

	// positions gather per sweep, then move to the output register as one item
	always_ff @(posedge clk) begin
		if (valid_s1 && op_s1 == msl_pkg::OP_TICK) begin
			acc_pos_q[idx_s1] <= new_pos;
		end
		if (done_tick && out_free) begin
			for (int j = 0; j < NJ - 1; j++) begin
				out_pos_q[j] <= acc_pos_q[j];
			end
			out_pos_q[NJ-1] <= new_pos;
		end else if (hold_q && out_free) begin
			out_pos_q <= acc_pos_q;
		end
	end

	for (genvar g = 0; g < NJ; g++) begin : g_out
		assign m_axis_tdata[VW*g +: VW] = out_pos_q[g];
	end
	if (msl_pkg::OUT_DATA_W > VW * NJ) begin : g_out_pad
		assign m_axis_tdata[msl_pkg::OUT_DATA_W-1:VW*NJ] = '0;
	end

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done_tick |-> !hold_q)
		else $error("tick result would overwrite a held result");

	a_start_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && idx_q == '0))
		else $error("sweep did not begin at joint zero");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (idx_s1 <= msl_pkg::LAST_IDX))
		else $error("joint RAM write beyond last joint");

	a_result_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(done_tick || hold_q))
		else $error("result raised outside the end of a sweep");
`endif

endmodule
